### src/ltd_pkg.sv
package ltd_pkg;

  // ring geometry (ring size is a power of two)
  localparam int RING_BYTES = 65536;
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int CNT_W      = PTR_W + 1;
  localparam int LIMIT_W    = 17;

  // line length limit: a line keeps at most LINE_BYTES-1 bytes
  localparam int LINE_BYTES = 256;
  localparam int LEN_W      = $clog2(LINE_BYTES);

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_START  = 2'd1,
    CMD_FETCH  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH
  } state_t;

  // one write port and one read port of the ring memory
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  // result of one transaction, valid for a single cycle
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       line_end;
    logic       drain_done;
  } res_t;

endpackage

### src/ltd_if.sv
interface ltd_in_if;
  import ltd_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         data_byte;
  logic [LIMIT_W-1:0] line_limit;

  modport source (output valid, cmd, data_byte, line_limit, input ready);
  modport sink   (input valid, cmd, data_byte, line_limit, output ready);
endinterface

interface ltd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       line_end;
  logic       drain_done;

  modport source (output valid, out_byte, out_valid, line_end, drain_done, input ready);
  modport sink   (input valid, out_byte, out_valid, line_end, drain_done, output ready);
endinterface

### src/ltd_ring_mem.sv
module ltd_ring_mem
  import ltd_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [RING_BYTES];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

### src/ltd_ctrl.sv
module ltd_ctrl
  import ltd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  logic [1:0]         cmd,
  input  logic [7:0]         data_byte,
  input  logic [LIMIT_W-1:0] line_limit,
  input  logic [7:0]         rd_data,
  output mem_req_t           mem_req,
  output res_t               res,
  output logic               idle
);

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   nl_r, nl_nxt;
  logic [CNT_W-1:0]   off_r, off_nxt;
  logic               active_r, active_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               skipping_r, skipping_nxt;
  logic [CNT_W-1:0]   tgt_r, tgt_nxt;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic               fix_pend_r, fix_pend_nxt;

  logic [CNT_W-1:0]   nl_eff;
  logic [CNT_W-1:0]   skip_cnt;
  logic [CNT_W-1:0]   limit_ext;
  logic [CNT_W-1:0]   off_inc;
  logic [CNT_W-1:0]   seen_inc;
  logic [LEN_W-1:0]   len_inc;
  logic [PTR_W-1:0]   base;
  logic               rd_nl;
  logic               ring_full;

  assign base      = wp_r - fill_r[PTR_W-1:0];
  assign rd_nl     = (rd_data == NEWLINE_CHAR);
  assign ring_full = (fill_r == CNT_W'(RING_BYTES));
  assign off_inc   = off_r + CNT_W'(1);
  assign seen_inc  = seen_r + CNT_W'(rd_nl);
  assign len_inc   = len_r + LEN_W'(1);
  assign limit_ext = CNT_W'(line_limit);
  assign idle      = (state_r == ST_IDLE);

  // lines to skip so that only the newest ones stay
  assign skip_cnt  = (nl_eff > limit_ext) ? (nl_eff - limit_ext) : '0;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wp_r       <= '0;
      fill_r     <= '0;
      nl_r       <= '0;
      off_r      <= '0;
      active_r   <= 1'b0;
      len_r      <= '0;
      skipping_r <= 1'b0;
      fix_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wp_r       <= wp_nxt;
      fill_r     <= fill_nxt;
      nl_r       <= nl_nxt;
      off_r      <= off_nxt;
      active_r   <= active_nxt;
      len_r      <= len_nxt;
      skipping_r <= skipping_nxt;
      fix_pend_r <= fix_pend_nxt;
    end
  end

  // scan bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    seen_r <= seen_nxt;
  end

  // next state, memory requests and results
  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    off_nxt      = off_r;
    active_nxt   = active_r;
    len_nxt      = len_r;
    skipping_nxt = skipping_r;
    tgt_nxt      = tgt_r;
    seen_nxt     = seen_r;
    fix_pend_nxt = 1'b0;
    mem_req      = '0;
    res          = '0;

    // overwritten newline from the previous append comes back now
    nl_eff = nl_r;
    if (fix_pend_r && rd_nl && (nl_r != '0)) begin
      nl_eff = nl_r - CNT_W'(1);
    end
    nl_nxt = nl_eff;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          res.valid = 1'b1;
          unique case (cmd_t'(cmd))
            CMD_APPEND: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = wp_r;
              mem_req.wdata = data_byte;
              mem_req.re    = 1'b1;
              mem_req.raddr = wp_r;
              if (ring_full) begin
                fix_pend_nxt = 1'b1;
              end else begin
                fill_nxt = fill_r + CNT_W'(1);
              end
              if (data_byte == NEWLINE_CHAR) begin
                nl_nxt = nl_eff + CNT_W'(1);
              end
              wp_nxt       = wp_r + PTR_W'(1);
              active_nxt   = 1'b0;
              off_nxt      = '0;
              len_nxt      = '0;
              skipping_nxt = 1'b0;
            end
            CMD_START: begin
              active_nxt   = 1'b0;
              off_nxt      = '0;
              len_nxt      = '0;
              skipping_nxt = 1'b0;
              if ((fill_r != '0) && (limit_ext != '0)) begin
                if (skip_cnt == '0) begin
                  active_nxt = 1'b1;
                end else begin
                  res.valid     = 1'b0;
                  state_nxt     = ST_SCAN;
                  tgt_nxt       = skip_cnt;
                  seen_nxt      = '0;
                  mem_req.re    = 1'b1;
                  mem_req.raddr = base;
                end
              end
            end
            CMD_FETCH: begin
              if (active_r && (off_r < fill_r)) begin
                res.valid     = 1'b0;
                state_nxt     = ST_FETCH;
                mem_req.re    = 1'b1;
                mem_req.raddr = base + off_r[PTR_W-1:0];
              end else begin
                res.drain_done = 1'b1;
                active_nxt     = 1'b0;
                off_nxt        = '0;
                len_nxt        = '0;
                skipping_nxt   = 1'b0;
              end
            end
            CMD_CLEAR: begin
              wp_nxt       = '0;
              fill_nxt     = '0;
              nl_nxt       = '0;
              active_nxt   = 1'b0;
              off_nxt      = '0;
              len_nxt      = '0;
              skipping_nxt = 1'b0;
            end
          endcase
        end
      end

      // walk past skipped lines, one byte per cycle
      ST_SCAN: begin
        off_nxt       = off_inc;
        seen_nxt      = seen_inc;
        mem_req.re    = 1'b1;
        mem_req.raddr = base + off_inc[PTR_W-1:0];
        if ((seen_inc == tgt_r) || (off_inc >= fill_r)) begin
          active_nxt = 1'b1;
          state_nxt  = ST_IDLE;
          res.valid  = 1'b1;
        end
      end

      // find the next kept byte
      ST_FETCH: begin
        off_nxt = off_inc;
        if (skipping_r) begin
          if (rd_nl) begin
            skipping_nxt = 1'b0;
            len_nxt      = '0;
          end
          if (off_inc >= fill_r) begin
            res.valid      = 1'b1;
            res.drain_done = 1'b1;
            state_nxt      = ST_IDLE;
            active_nxt     = 1'b0;
            off_nxt        = '0;
            len_nxt        = '0;
            skipping_nxt   = 1'b0;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = base + off_inc[PTR_W-1:0];
          end
        end else begin
          res.valid     = 1'b1;
          res.out_byte  = rd_data;
          res.out_valid = 1'b1;
          state_nxt     = ST_IDLE;
          len_nxt       = len_inc;
          if (rd_nl) begin
            res.line_end = 1'b1;
            len_nxt      = '0;
          end else if (len_inc >= LEN_W'(LINE_BYTES - 1)) begin
            res.line_end = 1'b1;
            skipping_nxt = 1'b1;
            len_nxt      = '0;
          end
          if (off_inc >= fill_r) begin
            res.line_end = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // newline correction only follows an append into a full ring
  a_fix_full: assert property (@(posedge clk) disable iff (!rst_n)
    fix_pend_r |-> ring_full)
    else $error("newline correction pending on a ring that is not full");

  // drain cursor stays inside the valid bytes
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (off_r <= fill_r))
    else $error("drain offset beyond fill count");

  // a fetch walk only runs on an active drain
  a_fetch_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (active_r && (off_r < fill_r)))
    else $error("fetch walk without an active drain");

  // skipping the tail of a line belongs to an active drain
  a_skip_active: assert property (@(posedge clk) disable iff (!rst_n)
    skipping_r |-> active_r)
    else $error("line tail skip outside a drain");

endmodule

### src/log_ring_tail_drain.sv
// log_ring_tail_drain: byte ring log store with a tail drain
//
// in_ch carries one command per transaction: append a byte, start a drain
// over the newest line_limit lines, fetch the next drained byte, or clear.
// out_ch returns exactly one result transaction for every command, in order.
// Append, clear, fetch without an active drain, and a start that skips
// nothing complete without leaving idle; appends stream at one per cycle
// while out_ch takes results. A start that skips lines walks the ring byte
// by byte up to the last skipped newline. A fetch reads bytes until one is
// kept, including the dropped tail of an over-long line. Both walks read the
// ring memory one entry per cycle through its single read port.
// Results sit in an output register; the next command is accepted while
// that register drains, and in_ch.ready drops when out_ch stalls with a
// result still held. After rst_n the ring is empty and no drain is active;
// ring contents are not cleared, only the fill count is.
module log_ring_tail_drain
  import ltd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ltd_in_if.sink    in_ch,
  ltd_out_if.source out_ch
);

  mem_req_t   mem_req;
  res_t       res;
  logic [7:0] rd_data;
  logic       ctrl_idle;
  logic       in_take;

  logic       outv_r;
  logic [7:0] obyte_r;
  logic       ovalid_r;
  logic       oend_r;
  logic       odone_r;

  // take a command only when idle and the result slot frees up
  assign in_ch.ready = ctrl_idle && (!outv_r || out_ch.ready);
  assign in_take     = in_ch.valid && in_ch.ready;

  ltd_ring_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  ltd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .cmd        (in_ch.cmd),
    .data_byte  (in_ch.data_byte),
    .line_limit (in_ch.line_limit),
    .rd_data    (rd_data),
    .mem_req    (mem_req),
    .res        (res),
    .idle       (ctrl_idle)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (res.valid) begin
      outv_r <= 1'b1;
    end else if (out_ch.ready) begin
      outv_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      obyte_r  <= res.out_byte;
      ovalid_r <= res.out_valid;
      oend_r   <= res.line_end;
      odone_r  <= res.drain_done;
    end
  end

  assign out_ch.valid      = outv_r;
  assign out_ch.out_byte   = obyte_r;
  assign out_ch.out_valid  = ovalid_r;
  assign out_ch.line_end   = oend_r;
  assign out_ch.drain_done = odone_r;

endmodule
